// ----- rtl/sprite_tile_blitter_assert.svh -----
// -----------------------------------------------------------------------------
// Sprite tile blitter assertion macros
// Concurrent checks clocked on clk and disabled while rst is high.
// -----------------------------------------------------------------------------
`ifndef SPRITE_TILE_BLITTER_ASSERT_SVH
`define SPRITE_TILE_BLITTER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication
`define STB_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication
`define STB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define STB_ASSERT_IMPL(name, ante, cons)
`define STB_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ----- rtl/stb_pkg.sv -----
// -----------------------------------------------------------------------------
// Sprite tile blitter package
// Beat types, status codes, control structs and the sheet character decoder.
// -----------------------------------------------------------------------------
package stb_pkg;

  // Default geometry
  localparam int SHEET_COUNT_DEF = 16;
  localparam int ROW_STRIDE_DEF  = 257;
  localparam int SHEET_BYTES_DEF = 65536;

  // Tile geometry
  localparam int TILE_SIDE = 16;

  // Item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  // Sheet character ranges
  localparam logic [7:0] CH_DIGIT_LO = 8'h31;  // '1'
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;  // '9'
  localparam logic [7:0] CH_ALPHA_LO = 8'h61;  // 'a'
  localparam logic [7:0] CH_ALPHA_HI = 8'h67;  // 'g'
  localparam logic [7:0] ALPHA_BASE  = 8'd9;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNLOADED  = 2'd1,
    ST_BAD_SHEET = 2'd2,
    ST_OOB       = 2'd3
  } status_t;

  // Input beat
  typedef struct packed {
    logic               func;
    logic        [4:0]  sheet_number;
    logic        [7:0]  tile_index;
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic        [15:0] load_address;
    logic        [7:0]  load_char;
  } in_item_t;

  // Output beat
  typedef struct packed {
    logic signed [15:0] row_x;
    logic signed [15:0] row_y;
    logic        [63:0] row_colours;
    logic        [1:0]  status;
    logic               last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic    write;      // load beat: store one character
    logic    capture;    // draw beat: latch item
    logic    start_row;  // set read pointer to current row
    logic    read;       // issue one sheet read
    logic    emit;       // push a result into the output register
    status_t emit_status;
    logic    advance;    // step to the next tile row
  } stb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_load;    // incoming beat is a load
    logic sheet_ok;
    logic loaded;
    logic row_oob;
    logic col_last;
    logic last_row;
    logic out_free;
  } stb_stat_t;

  // Sheet character to palette index
  function automatic logic [3:0] char_code(input logic [7:0] c);
    logic [3:0] r;
    r = 4'd0;
    if (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) begin
      r = 4'(c - CH_DIGIT_LO);
    end else if (c >= CH_ALPHA_LO && c <= CH_ALPHA_HI) begin
      r = 4'(c - CH_ALPHA_LO + ALPHA_BASE);
    end
    return r;
  endfunction

endpackage

// ----- rtl/stb_datapath.sv -----
// -----------------------------------------------------------------------------
// Sprite tile blitter datapath
// Sheet memory, load flags, row address walk, pixel assembly and output stage.
// -----------------------------------------------------------------------------
module stb_datapath
  import stb_pkg::*;
#(
  parameter int SHEET_COUNT = SHEET_COUNT_DEF,
  parameter int ROW_STRIDE  = ROW_STRIDE_DEF,
  parameter int SHEET_BYTES = SHEET_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  stb_cmd_t  cmd,
  output stb_stat_t stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int MEM_DEPTH = SHEET_COUNT * SHEET_BYTES;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int SIDX_W    = (SHEET_COUNT > 1) ? $clog2(SHEET_COUNT) : 1;
  localparam int PIX_W     = $clog2(256 * ROW_STRIDE + TILE_SIDE);
  localparam int CMP_W     = ((PIX_W > 17) ? PIX_W : 17) + 1;
  localparam int COL_W     = $clog2(TILE_SIDE);

  localparam logic [CMP_W-1:0]  SHEET_BYTES_C = CMP_W'(SHEET_BYTES);
  localparam logic [CMP_W-1:0]  ROW_SPAN_C    = CMP_W'(TILE_SIDE - 1);
  localparam logic [PIX_W-1:0]  TILE_ROW_C    = PIX_W'(TILE_SIDE * ROW_STRIDE);
  localparam logic [PIX_W-1:0]  STRIDE_C      = PIX_W'(ROW_STRIDE);
  localparam logic [MEM_AW-1:0] SHEET_SIZE_C  = MEM_AW'(SHEET_BYTES);
  localparam logic [5:0]        SHEET_MAX_C   = 6'(SHEET_COUNT);
  localparam logic [COL_W-1:0]  COL_LAST_C    = COL_W'(TILE_SIDE - 1);

  // Storage
  logic [3:0]             mem [MEM_DEPTH];
  logic [SHEET_COUNT-1:0] sheet_loaded;
  logic [3:0]             rd_data;
  logic                   rd_vld;

  // Captured draw
  logic [4:0]         draw_sheet;
  logic [MEM_AW-1:0]  sheet_base;
  logic [PIX_W-1:0]   row_start;
  logic [COL_W-1:0]   row;
  logic [COL_W-1:0]   col;
  logic [MEM_AW-1:0]  ptr;
  logic signed [15:0] row_x;
  logic signed [15:0] row_y;
  logic [63:0]        colours;

  // Load decode
  logic              ld_ok;
  logic [SIDX_W-1:0] ld_sidx;
  logic [SIDX_W-1:0] dr_sidx;
  logic [MEM_AW-1:0] wr_addr;

  assign ld_sidx = SIDX_W'(in_item.sheet_number - 5'd1);
  assign dr_sidx = SIDX_W'(draw_sheet - 5'd1);
  assign ld_ok   = (in_item.sheet_number != 5'd0)
                && (6'(in_item.sheet_number) <= SHEET_MAX_C)
                && (CMP_W'(in_item.load_address) < SHEET_BYTES_C);
  assign wr_addr = MEM_AW'(ld_sidx) * SHEET_SIZE_C + MEM_AW'(in_item.load_address);

  // Status to controller
  always_comb begin
    stat.in_load  = (in_item.func == FUNC_LOAD);
    stat.sheet_ok = (draw_sheet != 5'd0) && (6'(draw_sheet) <= SHEET_MAX_C);
    stat.loaded   = sheet_loaded[dr_sidx];
    stat.row_oob  = (CMP_W'(row_start) + ROW_SPAN_C) >= SHEET_BYTES_C;
    stat.col_last = (col == COL_LAST_C);
    stat.last_row = (row == COL_LAST_C);
    stat.out_free = !out_valid || !out_stall;
  end

  // Sheet memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.write && ld_ok) begin
      mem[wr_addr] <= char_code(in_item.load_char);
    end
    if (cmd.read) begin
      rd_data <= mem[ptr];
    end
  end

  // Load flags and read-valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      sheet_loaded <= '0;
      rd_vld       <= 1'b0;
    end else begin
      rd_vld <= cmd.read;
      if (cmd.write && ld_ok) begin
        sheet_loaded[ld_sidx] <= 1'b1;
      end
    end
  end

  // Draw walk: tile origin, row stepping, column pointer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      draw_sheet <= in_item.sheet_number;
      sheet_base <= MEM_AW'(SIDX_W'(in_item.sheet_number - 5'd1)) * SHEET_SIZE_C;
      row_start  <= PIX_W'(in_item.tile_index[7:4]) * TILE_ROW_C
                  + PIX_W'({in_item.tile_index[3:0], 4'b0000});
      row        <= '0;
      row_x      <= in_item.dest_x;
      row_y      <= in_item.dest_y;
    end else if (cmd.advance) begin
      row_start <= row_start + STRIDE_C;
      row       <= row + 1'b1;
      row_y     <= row_y + 16'sd1;
    end
    if (cmd.start_row) begin
      ptr <= sheet_base + MEM_AW'(row_start);
      col <= '0;
    end else if (cmd.read) begin
      ptr <= ptr + 1'b1;
      col <= col + 1'b1;
    end
    // leftmost pixel ends up in the lowest nibble
    if (rd_vld) begin
      colours <= {rd_data, colours[63:4]};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.status <= cmd.emit_status;
      out_item.last   <= (cmd.emit_status != ST_OK) || (row == COL_LAST_C);
      case (cmd.emit_status)
        ST_OK: begin
          out_item.row_x       <= row_x;
          out_item.row_y       <= row_y;
          out_item.row_colours <= colours;
        end
        ST_OOB: begin
          out_item.row_x       <= row_x;
          out_item.row_y       <= row_y;
          out_item.row_colours <= '0;
        end
        default: begin
          out_item.row_x       <= '0;
          out_item.row_y       <= '0;
          out_item.row_colours <= '0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/stb_ctrl.sv -----
// -----------------------------------------------------------------------------
// Sprite tile blitter controller
// Sequences load beats, draw checks, per-row sheet reads and result emission.
// -----------------------------------------------------------------------------
`include "sprite_tile_blitter_assert.svh"

module stb_ctrl
  import stb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  stb_stat_t stat,
  output stb_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ROW,
    S_READ,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t  state;
  status_t estat;

  // Only idle takes a beat
  assign in_stall = (state != S_IDLE);

  // Commands
  always_comb begin
    cmd             = '0;
    cmd.emit_status = estat;
    unique case (state)
      S_IDLE: begin
        cmd.write   = in_valid && stat.in_load;
        cmd.capture = in_valid && !stat.in_load;
      end
      S_ROW: begin
        cmd.start_row = !stat.row_oob;
      end
      S_READ: begin
        cmd.read = 1'b1;
      end
      S_EMIT: begin
        cmd.emit    = stat.out_free;
        cmd.advance = stat.out_free && (estat == ST_OK) && !stat.last_row;
      end
      default: begin
      end
    endcase
  end

  // State and pending status
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      estat <= ST_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && !stat.in_load) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!stat.sheet_ok) begin
            estat <= ST_BAD_SHEET;
            state <= S_EMIT;
          end else if (!stat.loaded) begin
            estat <= ST_UNLOADED;
            state <= S_EMIT;
          end else begin
            state <= S_ROW;
          end
        end
        S_ROW: begin
          if (stat.row_oob) begin
            estat <= ST_OOB;
            state <= S_EMIT;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (stat.col_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          estat <= ST_OK;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (stat.out_free) begin
            if (estat != ST_OK || stat.last_row) begin
              state <= S_IDLE;
            end else begin
              state <= S_ROW;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `STB_ASSERT_IMPL(a_emit_needs_room, cmd.emit, stat.out_free)
  `STB_ASSERT_IMPL(a_read_in_bounds, cmd.read, !stat.row_oob && stat.sheet_ok)
  `STB_ASSERT_NEXT(a_drain_after_last_col, state == S_READ && stat.col_last, state == S_DRAIN)
  `STB_ASSERT_NEXT(a_row_follows_ok_emit, cmd.emit && estat == ST_OK && !stat.last_row, state == S_ROW)

endmodule

// ----- rtl/sprite_tile_blitter.sv -----
// Load beat: taken while idle, writes the sheet store, produces no result.
// Draw beat: each tile row takes 16 sheet reads through the single memory read port
// plus the row setup, drain and emit states, and a full tile is sixteen rows; emit
// waits while the output is stalled. Error results go straight to emit, with no reads.
// Reset clears the sheet loaded flags, controller and output valid; the sheet
// store itself is not cleared and holds undefined data until written.
// -----------------------------------------------------------------------------
// Sprite tile blitter top level
// Stores character-coded sprite sheets and emits 16x16 tiles row by row.
// -----------------------------------------------------------------------------
module sprite_tile_blitter
  import stb_pkg::*;
#(
  parameter int SHEET_COUNT = SHEET_COUNT_DEF,
  parameter int ROW_STRIDE  = ROW_STRIDE_DEF,
  parameter int SHEET_BYTES = SHEET_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  stb_cmd_t  cmd;
  stb_stat_t stat;

  stb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  stb_datapath #(
    .SHEET_COUNT (SHEET_COUNT),
    .ROW_STRIDE  (ROW_STRIDE),
    .SHEET_BYTES (SHEET_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
